/* rtl/mfmd_pkg.sv */
// Shared constants, register codes and config struct for the MFM flux interval decoder.
// No dependencies; imported by every rtl module of the block.
package mfmd_pkg;

  localparam int DETECT_DEPTH = 10;
  localparam int TIME_WIDTH   = 32;

  localparam int CELL_W = 16;
  localparam int CNT_W  = $clog2(DETECT_DEPTH + 1);
  localparam int IDX_W  = (DETECT_DEPTH > 1) ? $clog2(DETECT_DEPTH) : 1;
  localparam int SUM_W  = TIME_WIDTH + $clog2(DETECT_DEPTH);
  localparam int LIM_W  = CELL_W + CNT_W;
  localparam int DEC_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int THR_W  = CELL_W + 3;
  localparam int CMP_W  = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;
  localparam int ACC_W  = 12;
  localparam int PEND_W = 4;
  localparam int BYTE_W = 8;
  localparam int VB_W   = 4;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [CELL_W-1:0] HD_CELL_RESET   = 16'd1000;
  localparam logic [CELL_W-1:0] DD_CELL_RESET   = 16'd2000;
  localparam logic [CELL_W-1:0] THRESHOLD_RESET = 16'd1500;

  typedef enum logic [1:0] {
    REG_HD_CELL   = 2'd0,
    REG_DD_CELL   = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CELL_W-1:0] hd_cell;
    logic [CELL_W-1:0] dd_cell;
    logic [CELL_W-1:0] threshold;
  } cfg_t;

endpackage

/* rtl/mfm_flux_interval_decoder_top.sv */
// MFM flux interval decoder top level: sequencer, detect buffer, shared window compare.
// Depends on mfmd_pkg and mfmd_cfg.
//
// Input channel (in_valid/in_ready) takes one flux transition timestamp per word,
// with in_last_transition marking the end of a track. Output channel
// (out_valid/out_ready) delivers packed raw bit bytes, MSB first; a flushed partial
// byte is left aligned and out_valid_bits tells how many bits count. The final word
// of a track carries out_end_of_track; a track that yields no bits ends with an
// empty marker word (valid_bits 0).
// in_ready is high only while the sequencer is idle. A decoded interval goes through
// one shared comparator that steps over the noise and window limits, one limit per
// cycle. The first up to DETECT_DEPTH intervals are only buffered; the density
// decision then replays them from the buffer memory through one read port.
// Results wait in a one-word hold stage plus the output register; while the
// receiver stalls the sequencer waits on its next result, and stops taking input.
// Synchronous reset returns registers to defaults and clears all track state.
module mfm_flux_interval_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mfmd_pkg::TIME_WIDTH-1:0] in_flux_time,
  input  logic                           in_last_transition,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mfmd_pkg::BYTE_W-1:0]     out_byte,
  output logic [mfmd_pkg::VB_W-1:0]       out_valid_bits,
  output logic                           out_end_of_track,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mfmd_pkg::CFG_AW-1:0]     paddr,
  input  logic [mfmd_pkg::CFG_DW-1:0]     pwdata,
  output logic [mfmd_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);
  import mfmd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_READ, S_LOAD, S_CMP, S_PACK,
    S_EMIT, S_NEXT, S_FLUSH, S_FINISH, S_DRAIN
  } state_t;

  cfg_t cfg;

  mfmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t                state_r;
  logic [TIME_WIDTH-1:0] prev_time_r;
  logic                  have_prev_r;
  logic [CNT_W-1:0]      count_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  phase_r;
  logic [THR_W-1:0]      wmin_r;
  logic [THR_W-1:0]      wmax_r;
  logic [ACC_W-1:0]      acc_r;
  logic [PEND_W-1:0]     pend_r;
  logic                  last_r;
  logic                  replay_r;
  logic                  flushing_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TIME_WIDTH-1:0] delta_r;
  logic [THR_W-1:0]      thr_r;
  logic [1:0]            step_r;
  logic [2:0]            len_r;
  logic [BYTE_W-1:0]     new_byte_r;
  logic [VB_W-1:0]       new_bits_r;
  logic                  hold_v_r;
  logic [BYTE_W-1:0]     hold_byte_r;
  logic [VB_W-1:0]       hold_bits_r;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_byte_r;
  logic [VB_W-1:0]       out_bits_r;
  logic                  out_eot_r;

  logic [TIME_WIDTH-1:0] buf_mem [DETECT_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data_r;

  logic                  accept;
  logic                  buf_we;
  logic [TIME_WIDTH-1:0] delta_in;
  logic [LIM_W-1:0]      limit;
  logic                  pick_hd;
  logic [CELL_W-1:0]     cell_sel;
  logic [THR_W-1:0]      cell_x3;
  logic [THR_W-1:0]      cell_x5;
  logic                  cmp_lt;
  logic [ACC_W-1:0]      acc_sh;
  logic [PEND_W-1:0]     pend_sum;
  logic [1:0]            rem;
  logic [ACC_W-1:0]      rem_mask;
  logic [BYTE_W-1:0]     full_byte;
  logic [BYTE_W-1:0]     flush_byte;
  logic                  out_free;
  logic                  out_load;

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_valid_bits   = out_bits_r;
  assign out_end_of_track = out_eot_r;
  assign out_free         = !out_valid_r || out_ready;
  assign out_load         = out_free && (state_r == S_FINISH ||
                            ((state_r == S_EMIT || state_r == S_DRAIN) && hold_v_r));

  assign buf_we   = accept && have_prev_r && !phase_r;
  assign delta_in = in_flux_time - prev_time_r;

  assign limit    = LIM_W'(cfg.threshold) * LIM_W'(count_r);
  assign pick_hd  = DEC_W'(sum_r) < DEC_W'(limit);
  assign cell_sel = pick_hd ? cfg.hd_cell : cfg.dd_cell;
  assign cell_x3  = THR_W'(cell_sel) + THR_W'({cell_sel, 1'b0});
  assign cell_x5  = THR_W'(cell_sel) + THR_W'({cell_sel, 2'b00});

  assign cmp_lt = CMP_W'(delta_r) < CMP_W'(thr_r);

  assign acc_sh     = ACC_W'((acc_r << len_r) | ACC_W'(1));
  assign pend_sum   = pend_r + PEND_W'(len_r);
  assign rem        = pend_sum[1:0];
  assign rem_mask   = ACC_W'((ACC_W'(1) << rem) - ACC_W'(1));
  assign full_byte  = BYTE_W'(acc_sh >> rem);
  assign flush_byte = BYTE_W'(acc_r << (PEND_W'(BYTE_W) - pend_r));

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[count_r[IDX_W-1:0]] <= delta_in;
    end
    rd_data_r <= buf_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_time_r <= '0;
      have_prev_r <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      phase_r     <= 1'b0;
      wmin_r      <= '0;
      wmax_r      <= '0;
      acc_r       <= '0;
      pend_r      <= '0;
      last_r      <= 1'b0;
      replay_r    <= 1'b0;
      flushing_r  <= 1'b0;
      idx_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            prev_time_r <= in_flux_time;
            have_prev_r <= 1'b1;
            last_r      <= in_last_transition;
            if (have_prev_r) begin
              if (!phase_r) begin
                count_r <= count_r + CNT_W'(1);
                sum_r   <= sum_r + SUM_W'(delta_in);
                if (in_last_transition || count_r == CNT_W'(DETECT_DEPTH - 1)) begin
                  state_r <= S_DECIDE;
                end
              end else begin
                delta_r <= delta_in;
                thr_r   <= wmin_r;
                step_r  <= 2'd0;
                state_r <= S_CMP;
              end
            end else if (in_last_transition) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_DECIDE: begin
          wmin_r   <= cell_x3 >> 2;
          wmax_r   <= cell_x5 >> 2;
          phase_r  <= 1'b1;
          idx_r    <= '0;
          replay_r <= 1'b1;
          state_r  <= S_READ;
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          delta_r <= rd_data_r;
          thr_r   <= wmin_r;
          step_r  <= 2'd0;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (step_r == 2'd0) begin
            if (cmp_lt) begin
              state_r <= S_NEXT;
            end else begin
              thr_r  <= wmax_r;
              step_r <= 2'd1;
            end
          end else if (cmp_lt || step_r == 2'd3) begin
            len_r   <= cmp_lt ? {1'b0, step_r} : 3'd4;
            state_r <= S_PACK;
          end else begin
            thr_r  <= thr_r + wmax_r;
            step_r <= step_r + 2'd1;
          end
        end
        S_PACK: begin
          if (pend_sum >= PEND_W'(BYTE_W)) begin
            new_byte_r <= full_byte;
            new_bits_r <= VB_W'(BYTE_W);
            acc_r      <= acc_sh & rem_mask;
            pend_r     <= PEND_W'(rem);
            state_r    <= S_EMIT;
          end else begin
            acc_r   <= acc_sh;
            pend_r  <= pend_sum;
            state_r <= S_NEXT;
          end
        end
        S_EMIT: begin
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              out_valid_r <= 1'b1;
              out_byte_r  <= hold_byte_r;
              out_bits_r  <= hold_bits_r;
              out_eot_r   <= 1'b0;
            end
            hold_v_r    <= 1'b1;
            hold_byte_r <= new_byte_r;
            hold_bits_r <= new_bits_r;
            state_r     <= flushing_r ? S_FINISH : S_NEXT;
          end
        end
        S_NEXT: begin
          if (replay_r && (CNT_W'(idx_r) + CNT_W'(1) < count_r)) begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_READ;
          end else begin
            replay_r <= 1'b0;
            state_r  <= last_r ? S_FLUSH : S_DRAIN;
          end
        end
        S_FLUSH: begin
          flushing_r <= 1'b1;
          if (pend_r != '0) begin
            new_byte_r <= flush_byte;
            new_bits_r <= VB_W'(pend_r);
            state_r    <= S_EMIT;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= hold_v_r ? hold_byte_r : '0;
            out_bits_r  <= hold_v_r ? hold_bits_r : '0;
            out_eot_r   <= 1'b1;
            hold_v_r    <= 1'b0;
            flushing_r  <= 1'b0;
            prev_time_r <= '0;
            have_prev_r <= 1'b0;
            count_r     <= '0;
            sum_r       <= '0;
            phase_r     <= 1'b0;
            wmin_r      <= '0;
            wmax_r      <= '0;
            acc_r       <= '0;
            pend_r      <= '0;
            last_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (!hold_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= hold_byte_r;
            out_bits_r  <= hold_bits_r;
            out_eot_r   <= 1'b0;
            hold_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/mfmd_cfg.sv */
// APB-style register bank: cell times and density threshold.
// Depends on mfmd_pkg.
module mfmd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfmd_pkg::CFG_AW-1:0] paddr,
  input  logic [mfmd_pkg::CFG_DW-1:0] pwdata,
  output logic [mfmd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output mfmd_pkg::cfg_t             cfg
);
  import mfmd_pkg::*;

  cfg_t     cfg_r;
  cfg_reg_t reg_idx;
  logic     wr_en;

  assign reg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hd_cell   <= HD_CELL_RESET;
      cfg_r.dd_cell   <= DD_CELL_RESET;
      cfg_r.threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HD_CELL:   cfg_r.hd_cell   <= pwdata[CELL_W-1:0];
        REG_DD_CELL:   cfg_r.dd_cell   <= pwdata[CELL_W-1:0];
        REG_THRESHOLD: cfg_r.threshold <= pwdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HD_CELL:   prdata = CFG_DW'(cfg_r.hd_cell);
      REG_DD_CELL:   prdata = CFG_DW'(cfg_r.dd_cell);
      REG_THRESHOLD: prdata = CFG_DW'(cfg_r.threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

/* rtl/mfmd_checker.sv */
// Port-level assertions for the MFM flux interval decoder, bound to the top level.
// Depends on mfmd_pkg and mfm_flux_interval_decoder_top.
module mfmd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mfmd_pkg::BYTE_W-1:0] out_byte,
  input logic [mfmd_pkg::VB_W-1:0]   out_valid_bits,
  input logic                       out_end_of_track
);
  import mfmd_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_valid_bits) && $stable(out_end_of_track))
    else $error("output word changed while stalled");

  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_track |-> out_valid_bits == VB_W'(BYTE_W))
    else $error("partial byte before end of track");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_bits == '0 |-> out_end_of_track && out_byte == '0)
    else $error("bad empty end marker");

  a_left_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_bits < VB_W'(BYTE_W) |-> (out_byte << out_valid_bits) == 8'h00)
    else $error("partial byte not left aligned");

endmodule

bind mfm_flux_interval_decoder_top mfmd_checker u_mfmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_valid_bits   (out_valid_bits),
  .out_end_of_track (out_end_of_track)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for mfm_flux_interval_decoder_top: directed transition table,
// then random tracks under several register settings, checked against a local decoder model.
// Depends on mfmd_pkg and the rtl of the block.
module tb_top;
  import mfmd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [VB_W-1:0]   nbits;
    logic              eot;
  } raw_word_t;

  typedef struct {
    logic [TIME_WIDTH-1:0] t;
    logic                  last;
    bit                    zero_regs;
    bit                    typed;
    logic [BYTE_W-1:0]     data;
    logic [VB_W-1:0]       nbits;
  } script_row_t;

  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = 4'hC;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [TIME_WIDTH-1:0] in_flux_time;
  logic                  in_last_transition;
  logic                  out_valid;
  logic                  out_ready;
  logic [BYTE_W-1:0]     out_byte;
  logic [VB_W-1:0]       out_valid_bits;
  logic                  out_end_of_track;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_AW-1:0]     paddr;
  logic [CFG_DW-1:0]     pwdata;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  // decoder model state
  logic [CELL_W-1:0]     reg_hd;
  logic [CELL_W-1:0]     reg_dd;
  logic [CELL_W-1:0]     reg_thr;
  logic [TIME_WIDTH-1:0] last_time;
  bit                    seen_first;
  logic [TIME_WIDTH-1:0] interval_buf [DETECT_DEPTH];
  int                    buf_count;
  logic [SUM_W-1:0]      buf_sum;
  bit                    locked;
  logic [CELL_W-1:0]     model_cell;
  int unsigned           shifter;
  int                    pend;

  raw_word_t bytes_due [$];
  raw_word_t step_words [$];
  int        errors;
  int        words_seen;
  bit        tx_burst;

  // first transition alone, one-bit track, every window class with wrap, noise only,
  // then all registers zero
  script_row_t script [23] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 8'h00, 4'd0},
    '{32'h1000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h1000_03E8, 1'b1, 1'b0, 1'b1, 8'h80, 4'd1},
    '{32'hFFFF_FC00, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'hFFFF_FFE8, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_03D0, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_0BA0, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_0F88, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_1B40, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_1F28, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_1FF0, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_23D8, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_27C0, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_2D9C, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_3D3C, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_421E, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_450B, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_47F9, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_47F8, 1'b1, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_0005, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h0000_000F, 1'b1, 1'b0, 1'b1, 8'h00, 4'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 8'h00, 4'd0},
    '{32'h0000_0063, 1'b1, 1'b0, 1'b1, 8'h10, 4'd4}
  };

  mfm_flux_interval_decoder_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_flux_time       (in_flux_time),
    .in_last_transition (in_last_transition),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_valid_bits     (out_valid_bits),
    .out_end_of_track   (out_end_of_track),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5000000;
    $display("FAIL mfm_flux_interval_decoder_top");
    $finish;
  end

  task report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task clear_track;
    last_time  = '0;
    seen_first = 1'b0;
    buf_count  = 0;
    buf_sum    = '0;
    locked     = 1'b0;
    model_cell = '0;
    shifter    = 0;
    pend       = 0;
  endtask

  task pack_interval(input logic [TIME_WIDTH-1:0] delta);
    longint unsigned wmin;
    longint unsigned wmax;
    int              len;
    wmin = (64'(model_cell) * 3) / 4;
    wmax = (64'(model_cell) * 5) / 4;
    if (64'(delta) < wmin) return;
    if (64'(delta) < wmax) len = 1;
    else if (64'(delta) < 2 * wmax) len = 2;
    else if (64'(delta) < 3 * wmax) len = 3;
    else len = 4;
    shifter = ((shifter << len) | 1) & 32'hFFF;
    pend += len;
    while (pend >= 8) begin
      step_words.push_back('{data: 8'(shifter >> (pend - 8)), nbits: 4'd8, eot: 1'b0});
      pend -= 8;
      shifter &= (32'd1 << pend) - 1;
    end
  endtask

  task choose_density;
    longint unsigned limit;
    limit      = 64'(reg_thr) * 64'(buf_count);
    model_cell = (64'(buf_sum) < limit) ? reg_hd : reg_dd;
    locked     = 1'b1;
    for (int i = 0; i < buf_count; i++) pack_interval(interval_buf[i]);
  endtask

  task decode_transition(input logic [TIME_WIDTH-1:0] t, input logic last);
    logic [TIME_WIDTH-1:0] delta;
    step_words.delete();
    if (seen_first) begin
      delta = t - last_time;
      if (!locked) begin
        if (buf_count < DETECT_DEPTH) begin
          interval_buf[buf_count] = delta;
          buf_count++;
          buf_sum += SUM_W'(delta);
        end
        if (buf_count >= DETECT_DEPTH) choose_density();
      end else begin
        pack_interval(delta);
      end
    end
    last_time  = t;
    seen_first = 1'b1;
    if (last) begin
      if (!locked && buf_count > 0) choose_density();
      if (pend > 0)
        step_words.push_back('{data: 8'(shifter << (8 - pend)), nbits: 4'(pend), eot: 1'b0});
      if (step_words.size() == 0) step_words.push_back('{data: 8'h00, nbits: 4'd0, eot: 1'b0});
      step_words[step_words.size() - 1].eot = 1'b1;
      clear_track();
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task send_word(input logic [TIME_WIDTH-1:0] t, input logic last);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_flux_time       <= t;
    in_last_transition <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CFG_AW-1:0] reg_addr(cfg_reg_t r);
    return {r, 2'b00};
  endfunction

  task cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr[CFG_AW-1:2])
      REG_HD_CELL:   reg_hd  = data[CELL_W-1:0];
      REG_DD_CELL:   reg_dd  = data[CELL_W-1:0];
      REG_THRESHOLD: reg_thr = data[CELL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task cfg_check(input cfg_reg_t r, input logic [CELL_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DW'(want))
      report_mismatch($sformatf("register %s reads %h, want %h", r.name(), prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task write_all(input logic [CFG_DW-1:0] hd, input logic [CFG_DW-1:0] dd,
                 input logic [CFG_DW-1:0] thr);
    cfg_write(reg_addr(REG_HD_CELL), hd);
    cfg_write(reg_addr(REG_DD_CELL), dd);
    cfg_write(reg_addr(REG_THRESHOLD), thr);
    cfg_write(UNMAPPED_ADDR, $urandom);
    cfg_check(REG_HD_CELL, reg_hd);
    cfg_check(REG_DD_CELL, reg_dd);
    cfg_check(REG_THRESHOLD, reg_thr);
  endtask

  // block may still be replaying after the last word of a track
  task wait_idle;
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  initial begin : drain
    raw_word_t want;
    bit        rx_burst;
    int        gap;
    out_ready <= 1'b0;
    rx_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (words_seen == 25 || words_seen == 120) gap = 400;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_seen++;
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte %h bits %0d end %0d",
                                  out_byte, out_valid_bits, out_end_of_track));
      end else begin
        want = bytes_due.pop_front();
        if (out_byte !== want.data || out_valid_bits !== want.nbits ||
            out_end_of_track !== want.eot)
          report_mismatch($sformatf("word byte %h bits %0d end %0d, want %h %0d %0d",
                                    out_byte, out_valid_bits, out_end_of_track,
                                    want.data, want.nbits, want.eot));
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_DW-1:0]     w0, w1, w2;
    logic [TIME_WIDTH-1:0] t;
    logic [CELL_W-1:0]     base_cell;
    int unsigned           span;
    int                    sent, track_len, r, k;
    raw_word_t             left;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_flux_time       <= '0;
    in_last_transition <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    errors     = 0;
    words_seen = 0;
    tx_burst   = 1'b0;
    reg_hd     = HD_CELL_RESET;
    reg_dd     = DD_CELL_RESET;
    reg_thr    = THRESHOLD_RESET;
    clear_track();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].zero_regs) begin
        wait_idle();
        write_all(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
      end
      send_word(script[i].t, script[i].last);
      decode_transition(script[i].t, script[i].last);
      if (script[i].typed)
        bytes_due.push_back('{data: script[i].data, nbits: script[i].nbits, eot: 1'b1});
      else
        foreach (step_words[j]) bytes_due.push_back(step_words[j]);
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          w0 = 32'd1000;
          w1 = 32'd2000;
          w2 = 32'd1500;
        end
        1: begin
          w0 = 32'hFFFF_FFFF;
          w1 = 32'h0000_FFFF;
          w2 = 32'hFFFF_FFFF;
        end
        2: begin
          w0 = 32'd1;
          w1 = 32'hFFFF_0001;
          w2 = 32'd1;
        end
        3: begin
          w0 = 32'd0;
          w1 = $urandom_range(1, 65535);
          w2 = $urandom_range(1, 65535);
        end
        4: begin
          w0 = {16'($urandom), 16'($urandom_range(300, 6000))};
          w1 = {16'($urandom), 16'($urandom_range(300, 6000))};
          w2 = {16'($urandom), 16'($urandom_range(300, 6000))};
        end
        default: begin
          w0 = $urandom;
          w1 = $urandom;
          w2 = $urandom;
        end
      endcase
      write_all(w0, w1, w2);
      sent = 0;
      while (sent < 60) begin
        r = $urandom_range(0, 9);
        track_len = (r == 0) ? 1 : (r == 1) ? $urandom_range(26, 40) : $urandom_range(2, 25);
        base_cell = $urandom_range(0, 1) ? reg_hd : reg_dd;
        span = (base_cell == 0) ? 8000 : 5 * base_cell;
        t = $urandom;
        for (int j = 0; j < track_len; j++) begin
          if (j > 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) t += $urandom;
            else if (r < 3) t += $urandom_range(0, 2 * span);
            else t += $urandom_range(0, span);
          end
          send_word(t, j == track_len - 1);
          decode_transition(t, j == track_len - 1);
          foreach (step_words[m]) bytes_due.push_back(step_words[m]);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    for (k = 0; k < 50000 && bytes_due.size() != 0; k++) @(negedge clk);
    repeat (120) @(negedge clk);
    while (bytes_due.size() != 0) begin
      left = bytes_due.pop_front();
      report_mismatch($sformatf("missing word byte %h bits %0d end %0d",
                                left.data, left.nbits, left.eot));
    end
    if (errors == 0) begin
      $display("PASS mfm_flux_interval_decoder_top");
    end else begin
      $display("FAIL mfm_flux_interval_decoder_top");
    end
    $finish;
  end

endmodule
